// ===== hw/rtl/snoise_pkg.sv =====
// Shared types, constants and helper functions for the 3D simplex noise block.
// Used by snoise_ctrl, snoise_dp and simplex_noise_3d_octaves. No dependencies.
package snoise_pkg;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 66;
	localparam int OCT_W  = 4;
	localparam int TOT_W  = 28;
	localparam int OUT_W  = 22;

	localparam logic [32:0] RECIP3    = 33'd5592406;
	localparam logic [32:0] INV3_24   = 33'h0_00AA_AAAB;
	localparam logic [36:0] FALLOFF   = 37'd644245094;
	localparam logic [22:0] DIV_BIAS  = 23'd3145728;
	localparam logic [20:0] REM_BIAS  = 21'd786432;
	localparam logic [21:0] SIX_UNIT  = 22'd393216;
	localparam logic [TOT_W-1:0] OCT_ONE = TOT_W'(65536);
	localparam logic signed [TOT_W-1:0] SAT_MAX = TOT_W'(2097151);
	localparam logic signed [TOT_W-1:0] SAT_MIN = -TOT_W'(2097152);

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_REM, OP_REM2, OP_OA, OP_OB, OP_OC, OP_OD,
		OP_CE, OP_MX, OP_DX, OP_DY, OP_DZ, OP_SX, OP_SY, OP_SZ,
		OP_T, OP_T2, OP_T4, OP_TM, OP_ACC, OP_OE, OP_OUT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [OCT_W-1:0] oct;
		logic [1:0]       corner;
	} cmd_t;

	typedef struct packed {
		logic t_neg;
		logic out_free;
	} stat_t;

	localparam logic [7:0] PERM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,
		8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,
		8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,
		8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,
		8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,
		8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,
		8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,
		8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,
		8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,
		8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,
		8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,
		8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
		8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
		8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
		8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
		8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,
		8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,
		8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,
		8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,
		8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
		8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
		8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
	};

	function automatic logic [3:0] mod12(input logic [7:0] h);
		logic [15:0] prod;
		logic [7:0]  q12;
		prod = 16'(h) * 16'd171;
		q12  = 8'(prod[15:11]) * 8'd12;
		return 4'(h - q12);
	endfunction

	// floor(e * 2^13 / 3) from q = floor((e + bias) / 3) and remainder b
	function automatic logic signed [32:0] scale_off(input logic [20:0] q,
			input logic [1:0] b);
		logic signed [35:0] acc;
		logic [12:0]        frac;
		case (b)
			2'd1:    frac = 13'd2730;
			2'd2:    frac = 13'd5461;
			default: frac = 13'd0;
		endcase
		acc = $signed({2'b0, q, 13'b0}) - 36'sh2_0000_0000 + $signed({23'b0, frac});
		return 33'(acc);
	endfunction

	function automatic logic signed [34:0] grad_dot(input logic [3:0] g,
			input logic signed [32:0] dx, input logic signed [32:0] dy,
			input logic signed [32:0] dz);
		logic signed [34:0] x, y, z, r;
		x = 35'(dx);
		y = 35'(dy);
		z = 35'(dz);
		case (g)
			4'd0:    r =  x + y;
			4'd1:    r = -x + y;
			4'd2:    r =  x - y;
			4'd3:    r = -x - y;
			4'd4:    r =  x + z;
			4'd5:    r = -x + z;
			4'd6:    r =  x - z;
			4'd7:    r = -x - z;
			4'd8:    r =  y + z;
			4'd9:    r = -y + z;
			4'd10:   r =  y - z;
			4'd11:   r = -y - z;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/snoise_ctrl.sv =====
// Sequencer for the simplex noise block: octave and corner loops, input handshake.
// Depends on snoise_pkg.
module snoise_ctrl #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          octave_count,
	input  snoise_pkg::stat_t   status,
	output snoise_pkg::cmd_t    cmd
);
	import snoise_pkg::*;

	localparam int CNT_W = $clog2(MAX_OCTAVES + 1);

	typedef enum logic [21:0] {
		S_IDLE = 22'h000001, S_REM  = 22'h000002, S_REM2 = 22'h000004,
		S_OA   = 22'h000008, S_OB   = 22'h000010, S_OC   = 22'h000020,
		S_OD   = 22'h000040, S_CE   = 22'h000080, S_MX   = 22'h000100,
		S_DX   = 22'h000200, S_DY   = 22'h000400, S_DZ   = 22'h000800,
		S_SX   = 22'h001000, S_SY   = 22'h002000, S_SZ   = 22'h004000,
		S_T    = 22'h008000, S_T2   = 22'h010000, S_T4   = 22'h020000,
		S_TM   = 22'h040000, S_ACC  = 22'h080000, S_OE   = 22'h100000,
		S_FIN  = 22'h200000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, oct_q, clamp;
	logic [1:0]       corner_q;
	logic             accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign clamp    = ({1'b0, octave_count} > 5'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES)
	                                                            : CNT_W'(octave_count);

	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NONE;
		cmd.oct    = OCT_W'(oct_q);
		cmd.corner = corner_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op  = OP_LOAD;
					state_d = (clamp == '0) ? S_FIN : S_REM;
				end
			end
			S_REM:  begin cmd.op = OP_REM;  state_d = S_REM2; end
			S_REM2: begin cmd.op = OP_REM2; state_d = S_OA;   end
			S_OA:   begin cmd.op = OP_OA;   state_d = S_OB;   end
			S_OB:   begin cmd.op = OP_OB;   state_d = S_OC;   end
			S_OC:   begin cmd.op = OP_OC;   state_d = S_OD;   end
			S_OD:   begin cmd.op = OP_OD;   state_d = S_CE;   end
			S_CE:   begin cmd.op = OP_CE;   state_d = S_MX;   end
			S_MX:   begin cmd.op = OP_MX;   state_d = S_DX;   end
			S_DX:   begin cmd.op = OP_DX;   state_d = S_DY;   end
			S_DY:   begin cmd.op = OP_DY;   state_d = S_DZ;   end
			S_DZ:   begin cmd.op = OP_DZ;   state_d = S_SX;   end
			S_SX:   begin cmd.op = OP_SX;   state_d = S_SY;   end
			S_SY:   begin cmd.op = OP_SY;   state_d = S_SZ;   end
			S_SZ:   begin cmd.op = OP_SZ;   state_d = S_T;    end
			S_T: begin
				cmd.op  = OP_T;
				state_d = status.t_neg ? S_ACC : S_T2;
			end
			S_T2:   begin cmd.op = OP_T2;   state_d = S_T4;   end
			S_T4:   begin cmd.op = OP_T4;   state_d = S_TM;   end
			S_TM:   begin cmd.op = OP_TM;   state_d = S_ACC;  end
			S_ACC: begin
				cmd.op  = OP_ACC;
				state_d = (corner_q == 2'd3) ? S_OE : S_CE;
			end
			S_OE: begin
				cmd.op  = OP_OE;
				state_d = (CNT_W'(oct_q + 1'b1) == cnt_q) ? S_FIN : S_OA;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			oct_q    <= '0;
			corner_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= clamp;
				oct_q <= '0;
			end
			if (state_q == S_OD)
				corner_q <= '0;
			else if (state_q == S_ACC)
				corner_q <= corner_q + 2'd1;
			if (state_q == S_OE)
				oct_q <= CNT_W'(oct_q + 1'b1);
		end
	end

endmodule

// ===== hw/rtl/snoise_dp.sv =====
// Datapath for the simplex noise block: skew, hashing, falloff, octave sum,
// one shared registered multiplier and the output register. Depends on snoise_pkg.
module snoise_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  snoise_pkg::cmd_t    cmd,
	output snoise_pkg::stat_t   status,
	input  logic [31:0]         x_coord,
	input  logic [31:0]         y_coord,
	input  logic [31:0]         z_coord,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [21:0]         noise_sum
);
	import snoise_pkg::*;

	logic [31:0]              x_q, y_q, z_q;
	logic [33:0]              s0_q;
	logic [1:0]               rem0_q, remo_q;
	logic [23:0]              xs_q, ys_q, zs_q, d24_q;
	logic [15:0]              fx_q, fy_q, fz_q;
	logic [7:0]               ix_q, iy_q, iz_q, h_q;
	logic signed [21:0]       e0x_q, e0y_q, e0z_q;
	logic [2:0]               step1_q, step2_q, abc_q;
	logic signed [20:0]       ex_q, ey_q, ez_q;
	logic [3:0]               g_q;
	logic signed [32:0]       dx_q, dy_q, dz_q, dot_q, t_q;
	logic [34:0]              r2_q;
	logic                     tneg_q;
	logic signed [63:0]       sum_q;
	logic signed [TOT_W-1:0]  total_q;
	logic signed [PROD_W-1:0] p_q;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic                     out_valid_q;
	logic [21:0]              noise_q;

	logic [20:0]        n_rem;
	logic [22:0]        nx_w, ny_w, nz_w, n_sel;
	logic [1:0]         rem_o, b_sel;
	logic [20:0]        q_div;
	logic signed [32:0] d_new;
	logic [35:0]        r2_all;
	logic signed [36:0] t_w;
	logic [17:0]        f_sum;
	logic [23:0]        slo;
	logic [2:0]         abc_w;
	logic signed [21:0] ecx_w, ecy_w, ecz_w, cunit;
	logic signed [21:0] e0x_w, e0y_w, e0z_w;
	logic [32:0]        p_sh;

	assign n_rem = 21'($signed({{3{s0_q[33]}}, s0_q[33:16]})) + 21'({5'b0, s0_q[15:0]})
	             + REM_BIAS;
	assign nx_w  = 23'($signed({{2{ex_q[20]}}, ex_q})) + DIV_BIAS;
	assign ny_w  = 23'($signed({{2{ey_q[20]}}, ey_q})) + DIV_BIAS;
	assign nz_w  = 23'($signed({{2{ez_q[20]}}, ez_q})) + DIV_BIAS;
	assign p_sh  = p_q[62:30];

	always_comb begin
		case (cmd.op)
			OP_DX:   n_sel = nx_w;
			OP_DY:   n_sel = ny_w;
			default: n_sel = nz_w;
		endcase
	end
	assign q_div = p_q[44:24];
	assign b_sel = 2'(n_sel[1:0] - 2'(q_div[1:0] * 2'd3));
	assign d_new = scale_off(q_div, b_sel);

	assign rem_o = cmd.oct[0] ? ((rem0_q == 2'd1) ? 2'd2 : (rem0_q == 2'd2) ? 2'd1 : 2'd0)
	                          : rem0_q;
	assign slo   = p_q[23:0];

	assign f_sum = 18'(fx_q) + 18'(fy_q) + 18'(fz_q);
	assign e0x_w = 22'({fx_q, 2'b0}) + 22'({fx_q, 1'b0}) + 22'(remo_q) - 22'(f_sum);
	assign e0y_w = 22'({fy_q, 2'b0}) + 22'({fy_q, 1'b0}) + 22'(remo_q) - 22'(f_sum);
	assign e0z_w = 22'({fz_q, 2'b0}) + 22'({fz_q, 1'b0}) + 22'(remo_q) - 22'(f_sum);

	always_comb begin
		case (cmd.corner)
			2'd0:    abc_w = 3'b000;
			2'd1:    abc_w = step1_q;
			2'd2:    abc_w = step2_q;
			default: abc_w = 3'b111;
		endcase
	end
	assign cunit = $signed({4'b0, cmd.corner, 16'b0});
	assign ecx_w = e0x_q - (abc_w[2] ? $signed(SIX_UNIT) : 22'sd0) + cunit;
	assign ecy_w = e0y_q - (abc_w[1] ? $signed(SIX_UNIT) : 22'sd0) + cunit;
	assign ecz_w = e0z_q - (abc_w[0] ? $signed(SIX_UNIT) : 22'sd0) + cunit;

	assign r2_all = 36'(r2_q) + 36'(p_q[63:30]);
	assign t_w    = $signed(FALLOFF) - $signed({1'b0, r2_all});

	assign status.t_neg    = t_w[36];
	assign status.out_free = !out_valid_q || out_ready;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_REM:              begin mul_a = $signed({12'b0, n_rem}); mul_b = RECIP3; end
			OP_OB:               begin mul_a = $signed({9'b0, d24_q}); mul_b = INV3_24; end
			OP_MX:               begin mul_a = $signed({10'b0, nx_w}); mul_b = RECIP3; end
			OP_DX:               begin mul_a = $signed({10'b0, ny_w}); mul_b = RECIP3; end
			OP_DY:               begin mul_a = $signed({10'b0, nz_w}); mul_b = RECIP3; end
			OP_SX:               begin mul_a = dx_q; mul_b = dx_q; end
			OP_SY:               begin mul_a = dy_q; mul_b = dy_q; end
			OP_SZ:               begin mul_a = dz_q; mul_b = dz_q; end
			OP_T2:               begin mul_a = t_q; mul_b = t_q; end
			OP_T4:               begin mul_a = $signed(p_sh); mul_b = $signed(p_sh); end
			OP_TM:               begin mul_a = $signed(p_sh); mul_b = dot_q; end
			default:             begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: begin
				x_q     <= x_coord;
				y_q     <= y_coord;
				z_q     <= z_coord;
				s0_q    <= 34'($signed(x_coord)) + 34'($signed(y_coord))
				         + 34'($signed(z_coord));
				total_q <= '0;
			end
			OP_REM2: rem0_q <= 2'(n_rem[1:0] - 2'(p_q[25:24] * 2'd3));
			OP_OA: begin
				xs_q   <= 24'(x_q << cmd.oct);
				ys_q   <= 24'(y_q << cmd.oct);
				zs_q   <= 24'(z_q << cmd.oct);
				d24_q  <= 24'(s0_q << cmd.oct) - 24'(rem_o);
				remo_q <= rem_o;
			end
			OP_OC: begin
				{ix_q, fx_q} <= xs_q + slo;
				{iy_q, fy_q} <= ys_q + slo;
				{iz_q, fz_q} <= zs_q + slo;
			end
			OP_OD: begin
				e0x_q <= e0x_w;
				e0y_q <= e0y_w;
				e0z_q <= e0z_w;
				sum_q <= '0;
				if (e0x_w >= e0y_w) begin
					if (e0y_w >= e0z_w)      begin step1_q <= 3'b100; step2_q <= 3'b110; end
					else if (e0x_w >= e0z_w) begin step1_q <= 3'b100; step2_q <= 3'b101; end
					else                     begin step1_q <= 3'b001; step2_q <= 3'b101; end
				end else begin
					if (e0y_w < e0z_w)       begin step1_q <= 3'b001; step2_q <= 3'b011; end
					else if (e0x_w < e0z_w)  begin step1_q <= 3'b010; step2_q <= 3'b011; end
					else                     begin step1_q <= 3'b010; step2_q <= 3'b110; end
				end
			end
			OP_CE: begin
				ex_q  <= 21'(ecx_w);
				ey_q  <= 21'(ecy_w);
				ez_q  <= 21'(ecz_w);
				abc_q <= abc_w;
				h_q   <= PERM[8'(iz_q + {7'b0, abc_w[0]})];
			end
			OP_MX: h_q <= PERM[8'(iy_q + {7'b0, abc_q[1]} + h_q)];
			OP_DX: begin
				dx_q <= d_new;
				h_q  <= PERM[8'(ix_q + {7'b0, abc_q[2]} + h_q)];
			end
			OP_DY: begin
				dy_q <= d_new;
				g_q  <= mod12(h_q);
			end
			OP_DZ: dz_q <= d_new;
			OP_SY: r2_q <= 35'(p_q[63:30]);
			OP_SZ: r2_q <= 35'(r2_all);
			OP_T: begin
				t_q    <= 33'(t_w);
				tneg_q <= t_w[36];
				dot_q  <= 33'(grad_dot(g_q, dx_q, dy_q, dz_q));
			end
			OP_ACC: if (!tneg_q) sum_q <= sum_q + 64'(p_q);
			OP_OE:  total_q <= total_q + TOT_W'($signed(sum_q[63:40])) + OCT_ONE;
			OP_OUT: begin
				if (total_q > SAT_MAX)
					noise_q <= 22'(SAT_MAX);
				else if (total_q < SAT_MIN)
					noise_q <= 22'(SAT_MIN);
				else
					noise_q <= total_q[21:0];
			end
			default: ;
		endcase
		if (cmd.op == OP_T2)
			tneg_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_OUT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign noise_sum = noise_q;

endmodule

// ===== hw/rtl/simplex_noise_3d_octaves.sv =====
// Top level of the octave-summed 3D simplex noise block.
// Depends on snoise_pkg, snoise_ctrl and snoise_dp.
//
//   channel  signals                                     transfer when
//   input    in_valid/in_ready, x/y/z_coord, octave_count in_valid & in_ready
//   output   out_valid/out_ready, noise_sum               out_valid & out_ready
//
// The datapath steps each item through its single shared multiplier: the load
// and remainder steps, per octave the offset steps, four corner passes and
// the octave sum; a corner outside the falloff radius skips its falloff steps.
// A result waits in the output register while the next item is taken in.
// Reset is asynchronous and returns the sequencer to idle with no result held.
module simplex_noise_3d_octaves #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] x_coord,
	input  logic [31:0] y_coord,
	input  logic [31:0] z_coord,
	input  logic [3:0]  octave_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [21:0] noise_sum
);
	import snoise_pkg::*;

	cmd_t  cmd;
	stat_t status;

	snoise_ctrl #(
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.octave_count (octave_count),
		.status       (status),
		.cmd          (cmd)
	);

	snoise_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.z_coord   (z_coord),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.noise_sum (noise_sum)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> status.out_free)
		else $error("output register overwritten before transfer");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.op == OP_OUT))
		else $error("result shown without a finished item");

endmodule
